FILE: src/tsp_pkg.sv
// Shared constants, codes and command/status types for the throttle smoother.
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int DUTY_BITS    = 14;

  localparam int KIND_W       = 2;
  localparam int IN_THR_W     = 16;
  localparam int THR_W        = 10;
  localparam int PULSE_W      = 11;
  localparam int TAU_W        = 10;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_W        = TAU_W;

  localparam int TICK_MS      = 20;
  localparam int PERIOD_US    = 20000;
  localparam int THROTTLE_MAX = 1000;
  localparam int PULSE_MIN    = 1000;
  localparam int PULSE_MAX    = 2000;
  localparam int TAU_MIN      = 10;
  localparam int TAU_MAX      = 1000;
  localparam int TAU_RST      = 100;

  localparam int FILT_W       = THR_W + FRAC_BITS;
  // |diff| * 20 needs five more bits than the filtered value
  localparam int PROD_W       = FILT_W + 5;
  localparam int DVD_W        = PROD_W;
  localparam int DVS_W        = $clog2(TAU_MAX + TICK_MS + 1);
  localparam int CNT_W        = $clog2(DVD_W);

  localparam int DUTY_MAX     = (1 << DUTY_BITS) - 1;
  localparam int DUTY_RST     = PULSE_MIN * DUTY_MAX / PERIOD_US;

  // reciprocal of the period, rounded up; the shift keeps the truncated
  // quotient exact for every pulse width up to PULSE_MAX
  localparam int     DUTY_SHIFT   = 26;
  localparam longint DUTY_RECIP   =
    ((longint'(DUTY_MAX) << DUTY_SHIFT) + PERIOD_US - 1) / PERIOD_US;
  localparam int     DUTY_RECIP_W = $clog2(DUTY_RECIP + 1);
  localparam int     DUTY_PROD_W  = PULSE_W + DUTY_RECIP_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_TARGET = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_STOP   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 1'b0,
    CFG_FILTER_TIME = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic apply;
    logic tick_load;
    logic div_step;
    logic tick_commit;
    logic duty_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic div_last;
  } sts_t;

endpackage

FILE: src/tsp_intf.sv
// Input and output word channels of the throttle smoother.
`timescale 1ns / 1ps

interface tsp_in_if import tsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IN_THR_W-1:0] throttle;

  modport source (output valid, kind, throttle, input ready);
  modport sink   (input valid, kind, throttle, output ready);
endinterface

interface tsp_out_if import tsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PULSE_W-1:0]   pulse_width;
  logic [DUTY_BITS-1:0] duty;
  logic [THR_W-1:0]     filtered_throttle;
  logic                 pulse_updated;
  logic                 ignored;

  modport source (output valid, pulse_width, duty, filtered_throttle, pulse_updated, ignored,
                  input ready);
  modport sink   (input valid, pulse_width, duty, filtered_throttle, pulse_updated, ignored,
                  output ready);
endinterface

FILE: src/throttle_smoothing_servo_pulse_unit.sv
// Top level of the throttle smoother with servo pulse and duty output.
//
// Usage: words arrive on in_i (kind, throttle) under valid/ready and each one
// gives exactly one word on out_o (pulse_width, duty, filtered_throttle,
// pulse_updated, ignored). Registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i (index 0 enable, index 1 filter time in ms, saturated to
// 10..1000); the user must write them only while the block is idle, which the
// block itself does not enforce. A disabled word, a set target or an emergency
// stop goes from acceptance straight to output; a direct set first passes the
// duty commit; a filter tick passes divider load, divide, filter commit and
// duty commit. The filter step uses a restoring divider that retires one
// quotient bit per cycle over a 31-bit dividend; the duty is a reciprocal multiply.
// One word is worked on at a time; in_i.ready is high whenever the controller
// is idle, so the next word is taken while a finished word still waits.
// A stalled receiver holds the finished word in the output register; a
// following word then waits in its last step until that register frees.
// Reset clears filter state to zero, the pulse to 1000 us, enable to 0 and
// the filter time to 100 ms.
`timescale 1ns / 1ps

module throttle_smoothing_servo_pulse_unit import tsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tsp_in_if.sink               in_i,
  tsp_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_kind_i   (in_i.kind),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsp_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_kind_i           (in_i.kind),
    .in_throttle_i       (in_i.throttle),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .pulse_width_o       (out_o.pulse_width),
    .duty_o              (out_o.duty),
    .filtered_throttle_o (out_o.filtered_throttle),
    .pulse_updated_o     (out_o.pulse_updated),
    .ignored_o           (out_o.ignored)
  );

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.pulse_width >= PULSE_W'(PULSE_MIN) &&
                     out_o.pulse_width <= PULSE_W'(PULSE_MAX)))
    else $error("pulse width out of range");

  a_filt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.filtered_throttle <= THR_W'(THROTTLE_MAX)))
    else $error("filtered throttle out of range");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.ignored && out_o.pulse_updated))
    else $error("ignored word reports a pulse update");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.tick_load || cmd.duty_commit) |-> !in_i.ready)
    else $error("input taken while divider busy");

endmodule

FILE: src/tsp_dpath.sv
// Datapath: registers, filter state, restoring divider, duty multiply and output word.
`timescale 1ns / 1ps

module tsp_dpath import tsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [KIND_W-1:0]    in_kind_i,
  input  logic [IN_THR_W-1:0]  in_throttle_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [PULSE_W-1:0]   pulse_width_o,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic [THR_W-1:0]     filtered_throttle_o,
  output logic                 pulse_updated_o,
  output logic                 ignored_o
);

  logic                 en_q;
  logic [TAU_W-1:0]     tau_q;
  logic [FILT_W-1:0]    filt_q, filt_d;
  logic [THR_W-1:0]     tgt_q, tgt_d;
  logic [PULSE_W-1:0]   pulse_q, pulse_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 upd_q, ign_q, dir_q, dir_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [PULSE_W-1:0]   out_pulse_q;
  logic [DUTY_BITS-1:0] out_duty_q;
  logic [THR_W-1:0]     out_filt_q;
  logic                 out_upd_q, out_ign_q;

  logic [THR_W-1:0]       thr_sat;
  logic [FILT_W-1:0]      goal, diff, filt_new;
  logic                   up;
  logic [DVD_W-1:0]       diff_x;
  logic [DVS_W:0]         trial, trial_sub;
  logic                   ge;
  logic [PULSE_W-1:0]     pulse_raw;
  logic [CFG_W-1:0]       tau_sat;
  logic [DUTY_PROD_W-1:0] duty_prod;

  // configuration
  always_comb begin
    tau_sat = cfg_data_i;
    if (cfg_data_i < CFG_W'(TAU_MIN)) tau_sat = CFG_W'(TAU_MIN);
    if (cfg_data_i > CFG_W'(TAU_MAX)) tau_sat = CFG_W'(TAU_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      tau_q <= TAU_W'(TAU_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:      en_q  <= cfg_data_i[0];
        CFG_FILTER_TIME: tau_q <= tau_sat;
        default: ;
      endcase
    end
  end

  assign thr_sat = (in_throttle_i > IN_THR_W'(THROTTLE_MAX)) ? THR_W'(THROTTLE_MAX)
                                                              : in_throttle_i[THR_W-1:0];

  assign goal   = {tgt_q, {FRAC_BITS{1'b0}}};
  assign up     = (goal >= filt_q);
  assign diff   = up ? (goal - filt_q) : (filt_q - goal);
  assign diff_x = DVD_W'(diff);

  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign ge        = (trial >= {1'b0, dvs_q});
  assign trial_sub = trial - {1'b0, dvs_q};

  assign filt_new  = dir_q ? (filt_q + dvd_q[FILT_W-1:0]) : (filt_q - dvd_q[FILT_W-1:0]);
  assign pulse_raw = PULSE_W'(PULSE_MIN) + PULSE_W'(filt_new[FILT_W-1:FRAC_BITS]);

  assign duty_prod = DUTY_PROD_W'(pulse_q) * DUTY_PROD_W'(DUTY_RECIP);

  always_comb begin
    filt_d  = filt_q;
    tgt_d   = tgt_q;
    pulse_d = pulse_q;
    duty_d  = duty_q;
    dir_d   = dir_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;

    if (cmd_i.apply && en_q) begin
      case (kind_e'(in_kind_i))
        KIND_TARGET: tgt_d = thr_sat;
        KIND_DIRECT: begin
          tgt_d   = thr_sat;
          filt_d  = {thr_sat, {FRAC_BITS{1'b0}}};
          pulse_d = PULSE_W'(PULSE_MIN) + PULSE_W'(thr_sat);
        end
        KIND_STOP: begin
          tgt_d   = '0;
          filt_d  = '0;
          pulse_d = PULSE_W'(PULSE_MIN);
          duty_d  = DUTY_BITS'(DUTY_RST);
        end
        default: ;
      endcase
    end

    if (cmd_i.tick_load) begin
      dvd_d = (diff_x << 4) + (diff_x << 2);
      dvs_d = DVS_W'(tau_q) + DVS_W'(TICK_MS);
      rem_d = '0;
      cnt_d = CNT_W'(DVD_W - 1);
      dir_d = up;
    end

    if (cmd_i.div_step) begin
      rem_d = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.tick_commit) begin
      filt_d  = filt_new;
      pulse_d = (pulse_raw > PULSE_W'(PULSE_MAX)) ? PULSE_W'(PULSE_MAX) : pulse_raw;
    end

    if (cmd_i.duty_commit) begin
      duty_d = DUTY_BITS'(duty_prod[DUTY_PROD_W-1:DUTY_SHIFT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      tgt_q   <= '0;
      pulse_q <= PULSE_W'(PULSE_MIN);
      duty_q  <= DUTY_BITS'(DUTY_RST);
      cnt_q   <= '0;
    end else begin
      filt_q  <= filt_d;
      tgt_q   <= tgt_d;
      pulse_q <= pulse_d;
      duty_q  <= duty_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= dir_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    if (cmd_i.apply) begin
      ign_q <= !en_q;
      upd_q <= en_q && (kind_e'(in_kind_i) != KIND_TARGET);
    end
    if (cmd_i.out_load) begin
      out_pulse_q <= pulse_q;
      out_duty_q  <= duty_q;
      out_filt_q  <= filt_q[FILT_W-1:FRAC_BITS];
      out_upd_q   <= upd_q;
      out_ign_q   <= ign_q;
    end
  end

  assign sts_o.enable   = en_q;
  assign sts_o.div_last = (cnt_q == '0);

  assign pulse_width_o       = out_pulse_q;
  assign duty_o              = out_duty_q;
  assign filtered_throttle_o = out_filt_q;
  assign pulse_updated_o     = out_upd_q;
  assign ignored_o           = out_ign_q;

endmodule

FILE: src/tsp_ctrl.sv
// Controller: sequences one word through apply, divider passes, filter and duty commits and output load.
`timescale 1ns / 1ps

module tsp_ctrl import tsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_TLOAD   = 6'b000010,
    ST_TDIV    = 6'b000100,
    ST_TCOMMIT = 6'b001000,
    ST_DCOMMIT = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          if (!sts_i.enable) begin
            state_d = ST_EMIT;
          end else begin
            case (kind_e'(in_kind_i))
              KIND_DIRECT: state_d = ST_DCOMMIT;
              KIND_TICK:   state_d = ST_TLOAD;
              default:     state_d = ST_EMIT;
            endcase
          end
        end
      end
      ST_TLOAD: begin
        cmd_o.tick_load = 1'b1;
        state_d         = ST_TDIV;
      end
      ST_TDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_TCOMMIT;
      end
      ST_TCOMMIT: begin
        cmd_o.tick_commit = 1'b1;
        state_d           = ST_DCOMMIT;
      end
      ST_DCOMMIT: begin
        cmd_o.duty_commit = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
